// ===== src/psof_pkg.sv =====
// Package for the sphere pair overlap finder.
// Holds the shared constants, the token and result structs of the cell chain
// and the controller state type. Depends on nothing.
package psof_pkg;

  localparam int MAX_SPHERES = 32;
  localparam int MAX_RESULTS = 32;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int OVL_W       = 11;
  localparam int DIST_W      = 17;
  localparam int D2_W        = 34;
  localparam logic [OVL_W-1:0] OVL_RESET = 11'd2016;
  localparam logic [OVL_W-1:0] OVL_SAT   = 11'd2047;

  localparam logic KIND_OVERLAP = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Query sphere travelling down the chain; rem counts cells left to pass.
  typedef struct packed {
    logic [IDX_W-1:0]  rem;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [15:0]       r;
  } tok_t;

  // Compare result left behind by the token in one cell.
  typedef struct packed {
    logic        valid;
    logic        done;
    logic [31:0] dx2;
    logic [31:0] dy2;
    logic [31:0] dz2;
    logic [33:0] rc2;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROOT,
    ST_FLUSH,
    ST_SUM
  } state_t;

endpackage

// ===== src/psof_if.sv =====
// Handshake interfaces for the sphere pair overlap finder.
// One interface for the sphere channel and one for the result channel.
// Depends on nothing.
interface psof_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_coord;
  logic signed [15:0] y_coord;
  logic signed [15:0] z_coord;
  logic [15:0]        radius;
  logic               last_atom;

  modport source (output valid, x_coord, y_coord, z_coord, radius, last_atom,
                  input ready);
  modport sink (input valid, x_coord, y_coord, z_coord, radius, last_atom,
                output ready);
endinterface

interface psof_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [5:0]  first_index;
  logic [5:0]  second_index;
  logic [16:0] distance;
  logic [10:0] total_count;
  logic        dropped;
  logic        last;

  modport source (output valid, kind, first_index, second_index, distance,
                  total_count, dropped, last, input ready);
  modport sink (input valid, kind, first_index, second_index, distance,
                total_count, dropped, last, output ready);
endinterface

// ===== src/psof_cell.sv =====
// One cell of the overlap chain: holds one stored sphere, squares the
// distance to the passing query and hands the query on. Uses psof_pkg.
module psof_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            tok_valid_i,
  input  psof_pkg::tok_t  tok_i,
  output logic            tok_valid_o,
  output psof_pkg::tok_t  tok_o,
  output psof_pkg::res_t  res_o
);

  logic signed [15:0] sx_r, sy_r, sz_r;
  logic [15:0]        sr_r;
  logic               tok_valid_r;
  psof_pkg::tok_t     tok_r, tok_nxt;
  logic               res_valid_r;
  logic               res_done_r;
  logic [31:0]        dx2_r, dy2_r, dz2_r;
  logic [33:0]        rc2_r;

  logic signed [16:0] dx, dy, dz;
  logic signed [33:0] px, py, pz;
  logic [16:0]        rc;
  logic [33:0]        rc2;
  logic               here;

  always_comb begin
    dx  = {tok_i.x[15], tok_i.x} - {sx_r[15], sx_r};
    dy  = {tok_i.y[15], tok_i.y} - {sy_r[15], sy_r};
    dz  = {tok_i.z[15], tok_i.z} - {sz_r[15], sz_r};
    px  = dx * dx;
    py  = dy * dy;
    pz  = dz * dz;
    rc  = {1'b0, tok_i.r} + {1'b0, sr_r};
    rc2 = rc * rc;
    // The token stops in the first free cell and stores its sphere there.
    here = (tok_i.rem == '0);
    tok_nxt     = tok_i;
    tok_nxt.rem = tok_i.rem - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else if (en) begin
      tok_valid_r <= tok_valid_i && !here;
      res_valid_r <= tok_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r      <= tok_nxt;
      res_done_r <= here;
      dx2_r <= px[31:0];
      dy2_r <= py[31:0];
      dz2_r <= pz[31:0];
      rc2_r <= rc2;
      if (tok_valid_i && here) begin
        sx_r <= tok_i.x;
        sy_r <= tok_i.y;
        sz_r <= tok_i.z;
        sr_r <= tok_i.r;
      end
    end
  end

  always_comb begin
    tok_valid_o = tok_valid_r;
    tok_o       = tok_r;
    // Gated so the chain outputs can be merged with a plain OR.
    res_o       = '0;
    if (res_valid_r) begin
      res_o.valid = 1'b1;
      res_o.done  = res_done_r;
      res_o.dx2   = dx2_r;
      res_o.dy2   = dy2_r;
      res_o.dz2   = dz2_r;
      res_o.rc2   = rc2_r;
    end
  end

endmodule

// ===== src/psof_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
// Takes a 34-bit squared distance and returns its 17-bit floor root.
// Uses psof_pkg.
module psof_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [psof_pkg::D2_W-1:0]     d_in,
  output logic                          busy,
  output logic [psof_pkg::DIST_W-1:0]   root
);

  logic                              busy_r, busy_nxt;
  logic [4:0]                        step_r, step_nxt;
  logic [psof_pkg::D2_W-1:0]         d_r, d_nxt;
  logic [19:0]                       rem_r, rem_nxt;
  logic [psof_pkg::DIST_W-1:0]       root_r, root_nxt;
  logic [19:0]                       shifted;
  logic [19:0]                       trial;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    shifted  = {rem_r[17:0], d_r[psof_pkg::D2_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 5'(psof_pkg::DIST_W - 1);
      d_nxt    = d_in;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      d_nxt = {d_r[psof_pkg::D2_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt  = shifted - trial;
        root_nxt = {root_r[psof_pkg::DIST_W-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        root_nxt = {root_r[psof_pkg::DIST_W-2:0], 1'b0};
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    d_r    <= d_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

// ===== src/sphere_pair_overlap_finder.sv =====
// Sphere pair overlap finder. A sphere is taken only while the block is idle;
// its query walks the cell chain one cell per cycle, and the chain holds while
// an emitted overlap waits on the bit-serial square root. Results leave
// through a one-deep output register. Synchronous active-low reset clears the
// counts and sets the overlap cap to 2016; stored spheres are not cleared.
module sphere_pair_overlap_finder #(
  parameter int MAX_SPHERES = psof_pkg::MAX_SPHERES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  psof_in_if.sink                      in_ch,
  psof_out_if.source                   out_ch,
  input  logic                         cfg_wr_en,
  input  logic [psof_pkg::OVL_W-1:0]   cfg_wr_data
);

  localparam logic [psof_pkg::CNT_W-1:0] CAP = psof_pkg::CNT_W'(MAX_SPHERES);
  localparam logic [4:0] RES_LIM = 5'(psof_pkg::MAX_RESULTS - 1);

  logic                          tok_valid [MAX_SPHERES+1];
  psof_pkg::tok_t                tok       [MAX_SPHERES+1];
  psof_pkg::res_t                res       [MAX_SPHERES];
  psof_pkg::res_t                res_sel;
  logic                          chain_en;

  psof_pkg::state_t              state_r, state_nxt;
  logic [psof_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [psof_pkg::OVL_W-1:0]    ovl_r, ovl_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          lasta_r, lasta_nxt;
  logic [psof_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [4:0]                    nres_r, nres_nxt;
  logic [psof_pkg::OVL_W-1:0]    maxov_r;
  logic [psof_pkg::IDX_W-1:0]    rec_first_r, rec_first_nxt;
  logic                          pend_valid_r, pend_valid_nxt;
  logic [psof_pkg::IDX_W-1:0]    pend_first_r, pend_first_nxt;
  logic [psof_pkg::DIST_W-1:0]   pend_dist_r, pend_dist_nxt;

  logic                          out_valid_r;
  logic                          out_kind_r, out_dropped_r, out_last_r;
  logic [psof_pkg::IDX_W-1:0]    out_first_r, out_second_r;
  logic [psof_pkg::DIST_W-1:0]   out_dist_r;
  logic [psof_pkg::OVL_W-1:0]    out_total_r;

  logic                          push;
  logic                          push_kind, push_dropped, push_last;
  logic [psof_pkg::IDX_W-1:0]    push_first, push_second;
  logic [psof_pkg::DIST_W-1:0]   push_dist;
  logic [psof_pkg::OVL_W-1:0]    push_total;
  logic                          out_free;
  logic                          in_acc;

  logic [psof_pkg::D2_W-1:0]     d2;
  logic                          hit;
  logic                          root_start;
  logic                          root_busy;
  logic [psof_pkg::DIST_W-1:0]   root_val;

  genvar g;
  generate
    for (g = 0; g < MAX_SPHERES; g++) begin : g_cell
      psof_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (chain_en),
        .tok_valid_i (tok_valid[g]),
        .tok_i       (tok[g]),
        .tok_valid_o (tok_valid[g+1]),
        .tok_o       (tok[g+1]),
        .res_o       (res[g])
      );
    end
  endgenerate

  psof_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .d_in  (d2),
    .busy  (root_busy),
    .root  (root_val)
  );

  // At most one cell holds a live result, so OR-merging selects it.
  always_comb begin
    res_sel = '0;
    for (int i = 0; i < MAX_SPHERES; i++) begin
      res_sel = res_sel | res[i];
    end
    d2  = psof_pkg::D2_W'(res_sel.dx2) + psof_pkg::D2_W'(res_sel.dy2)
        + psof_pkg::D2_W'(res_sel.dz2);
    hit = res_sel.valid && !res_sel.done && (d2 < res_sel.rc2);
  end

  assign in_ch.ready = (state_r == psof_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ovl_nxt        = ovl_r;
    ovf_nxt        = ovf_r;
    lasta_nxt      = lasta_r;
    idx_nxt        = idx_r;
    nres_nxt       = nres_r;
    rec_first_nxt  = rec_first_r;
    pend_valid_nxt = pend_valid_r;
    pend_first_nxt = pend_first_r;
    pend_dist_nxt  = pend_dist_r;
    chain_en       = 1'b0;
    root_start     = 1'b0;
    tok_valid[0]   = 1'b0;
    tok[0].rem     = cnt_r[psof_pkg::IDX_W-1:0];
    tok[0].x       = in_ch.x_coord;
    tok[0].y       = in_ch.y_coord;
    tok[0].z       = in_ch.z_coord;
    tok[0].r       = in_ch.radius;
    push           = 1'b0;
    push_kind      = psof_pkg::KIND_OVERLAP;
    push_first     = pend_first_r;
    push_second    = cnt_r[psof_pkg::IDX_W-1:0];
    push_dist      = pend_dist_r;
    push_total     = '0;
    push_dropped   = 1'b0;
    push_last      = 1'b0;

    unique case (state_r)
      psof_pkg::ST_IDLE: begin
        chain_en = 1'b1;
        if (in_acc) begin
          lasta_nxt = in_ch.last_atom;
          idx_nxt   = '0;
          nres_nxt  = '0;
          if (cnt_r < CAP) begin
            tok_valid[0] = 1'b1;
            state_nxt    = psof_pkg::ST_SCAN;
          end else begin
            ovf_nxt = 1'b1;
            if (in_ch.last_atom) begin
              state_nxt = psof_pkg::ST_FLUSH;
            end
          end
        end
      end
      psof_pkg::ST_SCAN: begin
        chain_en = 1'b1;
        if (res_sel.valid) begin
          if (res_sel.done) begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = psof_pkg::ST_FLUSH;
          end else begin
            idx_nxt = idx_r + 1'b1;
            if (hit) begin
              if (ovl_r != psof_pkg::OVL_SAT) begin
                ovl_nxt = ovl_r + 1'b1;
              end
              if ((ovl_r < maxov_r) && (nres_r < RES_LIM)) begin
                root_start    = 1'b1;
                rec_first_nxt = idx_r;
                nres_nxt      = nres_r + 1'b1;
                state_nxt     = psof_pkg::ST_ROOT;
              end
            end
          end
        end
      end
      psof_pkg::ST_ROOT: begin
        if (!root_busy) begin
          if (!pend_valid_r) begin
            pend_valid_nxt = 1'b1;
            pend_first_nxt = rec_first_r;
            pend_dist_nxt  = root_val;
            state_nxt      = psof_pkg::ST_SCAN;
          end else if (out_free) begin
            // A newer record exists, so the held one is not the step's last.
            push           = 1'b1;
            pend_first_nxt = rec_first_r;
            pend_dist_nxt  = root_val;
            state_nxt      = psof_pkg::ST_SCAN;
          end
        end
      end
      psof_pkg::ST_FLUSH: begin
        // When a sphere was stored, the count already includes it.
        push_second = psof_pkg::IDX_W'(cnt_r - 1'b1);
        if (pend_valid_r) begin
          if (out_free) begin
            push           = 1'b1;
            push_last      = !lasta_r;
            pend_valid_nxt = 1'b0;
            state_nxt      = lasta_r ? psof_pkg::ST_SUM : psof_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = lasta_r ? psof_pkg::ST_SUM : psof_pkg::ST_IDLE;
        end
      end
      psof_pkg::ST_SUM: begin
        push_kind    = psof_pkg::KIND_SUMMARY;
        push_first   = '0;
        push_second  = '0;
        push_dist    = '0;
        push_total   = ovl_r;
        push_dropped = ovf_r;
        push_last    = 1'b1;
        if (out_free) begin
          push      = 1'b1;
          cnt_nxt   = '0;
          ovl_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = psof_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = psof_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= psof_pkg::ST_IDLE;
      cnt_r        <= '0;
      ovl_r        <= '0;
      ovf_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      maxov_r      <= psof_pkg::OVL_RESET;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      ovl_r        <= ovl_nxt;
      ovf_r        <= ovf_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        maxov_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lasta_r      <= lasta_nxt;
    idx_r        <= idx_nxt;
    nres_r       <= nres_nxt;
    rec_first_r  <= rec_first_nxt;
    pend_first_r <= pend_first_nxt;
    pend_dist_r  <= pend_dist_nxt;
    if (push) begin
      out_kind_r    <= push_kind;
      out_first_r   <= push_first;
      out_second_r  <= push_second;
      out_dist_r    <= push_dist;
      out_total_r   <= push_total;
      out_dropped_r <= push_dropped;
      out_last_r    <= push_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.first_index  = out_first_r;
  assign out_ch.second_index = out_second_r;
  assign out_ch.distance     = out_dist_r;
  assign out_ch.total_count  = out_total_r;
  assign out_ch.dropped      = out_dropped_r;
  assign out_ch.last         = out_last_r;

  logic [MAX_SPHERES-1:0] res_valid_vec;
  always_comb begin
    for (int i = 0; i < MAX_SPHERES; i++) begin
      res_valid_vec[i] = res[i].valid;
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(res_valid_vec))
    else $error("more than one cell holds a compare result");

  a_root_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    root_start |-> !root_busy)
    else $error("square root started while busy");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psof_pkg::ST_IDLE) |-> !pend_valid_r)
    else $error("record left pending at end of step");

  a_sum_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psof_pkg::ST_SUM && out_free) |=> (cnt_r == '0 && ovl_r == '0))
    else $error("counts not cleared after summary");

endmodule
